>>> sv/spx_pkg.sv
// Package: widths, constants, register indexes and pipeline types for the pixel mapper.
`default_nettype none
package spx_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int QUO_W   = 7;
  localparam int REM_W   = COORD_W + QUO_W;
  localparam int PIX_W   = 8;
  localparam int CELLS   = QUO_W;

  localparam logic [PIX_W-1:0] SCREEN_SPAN = PIX_W'(127);
  localparam logic [PIX_W-1:0] SCREEN_TOP  = PIX_W'(32);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } spx_reg_idx_t;

  // One divider lane: partial remainder, divisor pre-shifted by QUO_W-1, quotient so far.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } spx_lane_t;

  // What travels from cell to cell.
  typedef struct packed {
    logic      valid;
    logic      ok;
    logic      last;
    spx_lane_t lx;
    spx_lane_t ly;
  } spx_cell_t;

  // Window registers as seen by the front end.
  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
  } spx_window_t;

endpackage : spx_pkg
`default_nettype wire

>>> sv/spx_point_if.sv
// Interface: input point channel (valid/ready plus point payload).
`default_nettype none
interface spx_point_if
  import spx_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface : spx_point_if
`default_nettype wire

>>> sv/spx_pixel_if.sv
// Interface: result pixel channel (valid/ready plus pixel payload).
`default_nettype none
interface spx_pixel_if
  import spx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             plotted;
  logic             last_of_run;
  logic             batch_end;

  modport source (output valid, output pixel_x, output pixel_y, output plotted,
                  output last_of_run, output batch_end, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input plotted,
                  input last_of_run, input batch_end, output ready);
endinterface : spx_pixel_if
`default_nettype wire

>>> sv/spx_front.sv
// Front end: window differences, range checks and scaled numerators (two stages).
`default_nettype none
module spx_front
  import spx_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      in_valid,
  input  wire logic signed [COORD_W-1:0] in_x,
  input  wire logic signed [COORD_W-1:0] in_y,
  input  wire logic                      in_last,
  input  wire spx_window_t               win,
  output spx_cell_t                      cell_out
);

  // stage A: signed differences
  logic                     a_valid_r;
  logic                     a_last_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_xr_r, a_yr_r;

  // stage B
  spx_cell_t b_r, b_nxt;
  logic      ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
    if (adv) begin
      a_last_r <= in_last;
      a_dx_r   <= DIFF_W'(in_x) - DIFF_W'(win.x_min);
      a_dy_r   <= DIFF_W'(win.y_max) - DIFF_W'(in_y);
      a_xr_r   <= DIFF_W'(win.x_max) - DIFF_W'(win.x_min);
      a_yr_r   <= DIFF_W'(win.y_max) - DIFF_W'(win.y_min);
    end
  end

  // x >= xmin, x <= xmax, y <= ymax, y >= ymin, and both ranges positive
  assign ok = (a_dx_r >= 0) && (a_dx_r <= a_xr_r) && (a_dy_r >= 0) && (a_dy_r <= a_yr_r)
              && (a_xr_r > 0) && (a_yr_r > 0);

  always_comb begin
    b_nxt        = '0;
    b_nxt.valid  = a_valid_r;
    b_nxt.ok     = ok;
    b_nxt.last   = a_last_r;
    b_nxt.lx.rem = REM_W'(a_dx_r[COORD_W-1:0]) * REM_W'(SCREEN_SPAN);
    b_nxt.ly.rem = REM_W'(a_dy_r[COORD_W-1:0]) * REM_W'(SCREEN_SPAN);
    b_nxt.lx.dvs = REM_W'({a_xr_r[COORD_W-1:0], (QUO_W-1)'(0)});
    b_nxt.ly.dvs = REM_W'({a_yr_r[COORD_W-1:0], (QUO_W-1)'(0)});
    b_nxt.lx.quo = '0;
    b_nxt.ly.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r.valid <= b_nxt.valid;
    end
    if (adv) begin
      b_r.ok   <= b_nxt.ok;
      b_r.last <= b_nxt.last;
      b_r.lx   <= b_nxt.lx;
      b_r.ly   <= b_nxt.ly;
    end
  end

  assign cell_out = b_r;

endmodule : spx_front
`default_nettype wire

>>> sv/spx_div_cell.sv
// Divider cell: one restoring quotient bit for both axes, registered.
`default_nettype none
module spx_div_cell
  import spx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire spx_cell_t d_in,
  output spx_cell_t      d_out
);

  spx_cell_t c_r, c_nxt;

  function automatic spx_lane_t lane_step(spx_lane_t l);
    spx_lane_t        r;
    logic             ge;
    logic [REM_W-1:0] rn;
    ge    = (l.rem >= l.dvs);
    rn    = ge ? (l.rem - l.dvs) : l.rem;
    r.rem = {rn[REM_W-2:0], 1'b0};
    r.dvs = l.dvs;
    r.quo = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    c_nxt    = d_in;
    c_nxt.lx = lane_step(d_in.lx);
    c_nxt.ly = lane_step(d_in.ly);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (adv) begin
      c_r.valid <= c_nxt.valid;
    end
    if (adv) begin
      c_r.ok   <= c_nxt.ok;
      c_r.last <= c_nxt.last;
      c_r.lx   <= c_nxt.lx;
      c_r.ly   <= c_nxt.ly;
    end
  end

  assign d_out = c_r;

endmodule : spx_div_cell
`default_nettype wire

>>> sv/spx_emit.sv
// Output stage: holds one mapped point and plays out its one or four pixel transactions.
`default_nettype none
module spx_emit
  import spx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire spx_cell_t d_in,
  output logic           adv,
  spx_pixel_if.source    out_px
);

  logic             hold_v_r;
  logic             ok_r, last_r;
  logic [QUO_W-1:0] qx_r, qy_r;
  logic [1:0]       beat_r, beat_nxt;
  logic             fin;
  logic             take;

  assign fin  = !ok_r || (beat_r == 2'd3);
  assign adv  = !hold_v_r || (out_px.ready && fin);
  assign take = out_px.ready && hold_v_r;

  always_comb begin
    beat_nxt = beat_r;
    if (adv) begin
      beat_nxt = 2'd0;
    end else if (take) begin
      beat_nxt = beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      beat_r   <= 2'd0;
    end else begin
      beat_r <= beat_nxt;
      if (adv) begin
        hold_v_r <= d_in.valid;
      end
    end
    if (adv) begin
      ok_r   <= d_in.ok;
      last_r <= d_in.last;
      qx_r   <= d_in.lx.quo;
      qy_r   <= d_in.ly.quo;
    end
  end

  assign out_px.valid       = hold_v_r;
  assign out_px.plotted     = ok_r;
  assign out_px.batch_end   = last_r;
  assign out_px.last_of_run = fin;
  assign out_px.pixel_x     = ok_r ? (PIX_W'(qx_r) + PIX_W'(beat_r[0])) : '0;
  assign out_px.pixel_y     = ok_r ? (SCREEN_TOP + PIX_W'(qy_r) + PIX_W'(beat_r[1])) : '0;

endmodule : spx_emit
`default_nettype wire

>>> sv/scatter_point_to_screen_pixels_unit.sv
// Top level: scatter point to screen pixel mapper.
// A point (signed 32-bit milli-unit x, y and a last-point flag) is checked against the
// window held in four registers and, when inside and both ranges are positive, mapped to
// sx = 127*(x-xmin)/(xmax-xmin) and sy = 32 + 127*(ymax-y)/(ymax-ymin), truncating; the
// block then gives four pixel transactions (sx,sy), (sx+1,sy), (sx,sy+1), (sx+1,sy+1).
// Any other point gives one transaction with plotted low and zero coordinates. The
// points flow through two front-end stages and a row of seven divider cells, each cell
// settling one quotient bit for both axes, so one point can enter every cycle unless
// the output stage stalls the row. The output stage sets the sustained rate: a plotted
// point occupies it for four transactions, a rejected point for one. The whole row stalls
// while the output stage is still playing out a point, so in_pt.ready follows out_px.ready
// combinationally. Window registers (reset to zero) are written through cfg_we / cfg_idx /
// cfg_data, by the user only while no point is in flight; the block does not enforce this.
`default_nettype none
module scatter_point_to_screen_pixels_unit
  import spx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  spx_point_if.sink                 in_pt,
  spx_pixel_if.source               out_px,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  spx_window_t win_r;
  logic        adv;
  spx_cell_t   row [CELLS+1];

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_we) begin
      case (spx_reg_idx_t'(cfg_idx))
        REG_X_MIN: win_r.x_min <= cfg_data;
        REG_X_MAX: win_r.x_max <= cfg_data;
        REG_Y_MIN: win_r.y_min <= cfg_data;
        REG_Y_MAX: win_r.y_max <= cfg_data;
        default:   win_r <= win_r;
      endcase
    end
  end

  // the whole row moves together whenever the output stage can take a point
  assign in_pt.ready = adv;

  spx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_pt.valid),
    .in_x     (in_pt.point_x),
    .in_y     (in_pt.point_y),
    .in_last  (in_pt.last_point),
    .win      (win_r),
    .cell_out (row[0])
  );

  // divider row, most significant quotient bit first
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    spx_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_in  (row[g]),
      .d_out (row[g+1])
    );
  end

  spx_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .d_in   (row[CELLS]),
    .adv    (adv),
    .out_px (out_px)
  );

endmodule : scatter_point_to_screen_pixels_unit
`default_nettype wire
